### sv/pat_pkg.sv
// ----------------------------------------------------------------------------
// Paged address translation unit package
// Operation codes, register addresses, status bits and shared types.
// ----------------------------------------------------------------------------
package pat_pkg;

  typedef enum logic [1:0] {
    OP_XLATE_READ  = 2'd0,
    OP_XLATE_WRITE = 2'd1,
    OP_REG_READ    = 2'd2,
    OP_REG_WRITE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] grp;
  } page_sel_t;

  localparam int MEM_DEPTH = 48;
  localparam int MEM_IDX_W = 6;

  localparam logic [1:0] GRP_KERNEL = 2'd0;
  localparam logic [1:0] GRP_SUPER  = 2'd1;
  localparam logic [1:0] GRP_USER   = 2'd2;

  localparam logic [2:0] ACC_RW    = 3'd6;
  localparam logic [2:0] ACC_RO    = 3'd2;
  localparam logic [2:0] ACC_NONE0 = 3'd0;
  localparam logic [2:0] ACC_NONE4 = 3'd4;

  localparam logic [15:0] SR0_CLR_MASK  = 16'o160156;
  localparam logic [15:0] SR0_ERR_NRES  = 16'o100000;
  localparam logic [15:0] SR0_ERR_LEN   = 16'o040000;
  localparam logic [15:0] SR0_ERR_RO    = 16'o020000;
  localparam logic [15:0] SR0_USER_MODE = 16'o000140;
  localparam logic [15:0] DESC_MASK     = 16'o077417;

  localparam logic [17:0] ADDR_SR0    = 18'o777572;
  localparam logic [17:0] ADDR_SR1    = 18'o777574;
  localparam logic [17:0] ADDR_SR2    = 18'o777576;
  localparam logic [17:0] ADDR_SR3    = 18'o772516;
  localparam logic [17:0] BASE_KERNEL = 18'o772300;
  localparam logic [17:0] BASE_SUPER  = 18'o772200;
  localparam logic [17:0] BASE_USER   = 18'o777600;

  localparam logic [2:0] IO_WINDOW_PAGE = 3'b111;
  localparam logic [1:0] IO_PAGE_HIGH   = 2'b11;

endpackage

### sv/paged_address_translation_unit.sv
// ----------------------------------------------------------------------------
// Paged address translation unit
// Translates 16-bit virtual addresses and serves the management registers.
//
// Usage: an operation word is taken at a rising edge with start high and
// busy low. At the accepting edge the unit reads the page address and
// descriptor memories (one synchronous read each); in the following cycle
// it checks, modifies and writes back. The result word is then on
// phys_addr, read_data, abort and bad_register, with done high for exactly
// one cycle; the receiver cannot stall it. A new word is not accepted while
// busy is high; it can be accepted in the cycle in which done is high.
// Reset clears the status registers, disables translation and marks every
// page word as zero through per-entry valid bits; no clearing pass is run.
// ----------------------------------------------------------------------------
module paged_address_translation_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [17:0] address,
  input  logic [15:0] write_data,
  input  logic        byte_access,
  input  logic        user_mode,
  input  logic [15:0] fetch_record,
  output logic        done,
  output logic [22:0] phys_addr,
  output logic [15:0] read_data,
  output logic        abort,
  output logic        bad_register
);
  import pat_pkg::*;

  function automatic page_sel_t page_select(input logic [17:0] a);
    page_sel_t s;
    s.hit = 1'b1;
    s.grp = GRP_KERNEL;
    if (a[17:6] == BASE_USER[17:6]) begin
      s.grp = GRP_USER;
    end else if (a[17:6] == BASE_SUPER[17:6]) begin
      s.grp = GRP_SUPER;
    end else if (a[17:6] == BASE_KERNEL[17:6]) begin
      s.grp = GRP_KERNEL;
    end else begin
      s.hit = 1'b0;
    end
    return s;
  endfunction

  function automatic logic [15:0] pick_word(input logic [15:0] v, input logic odd,
                                            input logic bsel);
    if (!bsel) begin
      return v;
    end
    return odd ? {8'h00, v[15:8]} : {8'h00, v[7:0]};
  endfunction

  function automatic logic [15:0] merge_word(input logic [15:0] old, input logic [15:0] val,
                                             input logic odd, input logic bsel);
    if (!bsel) begin
      return val;
    end
    return odd ? {val[7:0], old[7:0]} : {old[15:8], val[7:0]};
  endfunction

  state_t state;

  op_t         op_q;
  logic [17:0] addr_q;
  logic [15:0] wd_q;
  logic        byte_q;
  logic        user_q;
  logic [15:0] fetch_q;
  logic [MEM_IDX_W-1:0] idx_q;

  logic [15:0] status_zero;
  logic [15:0] status_one;
  logic [15:0] status_three;
  logic [15:0] status_zero_next;
  logic [15:0] status_one_next;
  logic [15:0] status_three_next;

  logic [15:0] desc_mem [MEM_DEPTH];
  logic [15:0] par_mem  [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] desc_vld;
  logic [MEM_DEPTH-1:0] par_vld;
  logic [15:0] desc_rd;
  logic [15:0] par_rd;
  logic        desc_hit;
  logic        par_hit;

  logic                 accept;
  page_sel_t            in_sel;
  logic [MEM_IDX_W-1:0] rd_idx;

  page_sel_t   q_sel;
  logic [15:0] pdr;
  logic [15:0] par;
  logic [15:0] page_old;
  logic [15:0] page_new;
  logic        desc_we;
  logic        par_we;

  logic [22:0] res_phys;
  logic [15:0] res_rd;
  logic        res_abort;
  logic        res_bad;

  logic        fail;
  logic        pending;
  logic [6:0]  blk;
  logic [6:0]  plf;
  logic [16:0] frame;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  always_comb begin
    in_sel = page_select(address);
    if (!operation[1]) begin
      rd_idx = {(user_mode ? GRP_USER : GRP_KERNEL), 1'b0, address[15:13]};
    end else begin
      rd_idx = {in_sel.grp, address[4:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      desc_rd  <= desc_mem[rd_idx];
      par_rd   <= par_mem[rd_idx];
      desc_hit <= desc_vld[rd_idx];
      par_hit  <= par_vld[rd_idx];
      idx_q    <= rd_idx;
      op_q     <= op_t'(operation);
      addr_q   <= address;
      wd_q     <= write_data;
      byte_q   <= byte_access;
      user_q   <= user_mode;
      fetch_q  <= fetch_record;
    end
    if (desc_we) begin
      desc_mem[idx_q] <= page_new;
    end
    if (par_we) begin
      par_mem[idx_q] <= page_new;
    end
  end

  assign pdr      = desc_hit ? desc_rd : 16'h0000;
  assign par      = par_hit ? par_rd : 16'h0000;
  assign q_sel    = page_select(addr_q);
  assign page_old = addr_q[5] ? par : pdr;
  assign blk      = addr_q[12:6];
  assign plf      = pdr[14:8];
  assign frame    = {1'b0, par} + {10'd0, blk};

  always_comb begin
    status_zero_next  = status_zero;
    status_one_next   = status_one;
    status_three_next = status_three;
    page_new  = merge_word(page_old, wd_q, addr_q[0], byte_q);
    desc_we   = 1'b0;
    par_we    = 1'b0;
    res_phys  = '0;
    res_rd    = '0;
    res_abort = 1'b0;
    res_bad   = 1'b0;
    fail      = 1'b0;
    pending   = 1'b0;
    if (!addr_q[5]) begin
      page_new = page_new & DESC_MASK;
    end
    if (state == ST_EXEC) begin
      if (!op_q[1]) begin
        if (!status_zero[0]) begin
          res_phys = {5'd0, ((addr_q[15:13] == IO_WINDOW_PAGE) ? IO_PAGE_HIGH : 2'b00),
                      addr_q[15:0]};
        end else begin
          unique case (pdr[2:0])
            ACC_RW: begin
            end
            ACC_RO: begin
              if (op_q == OP_XLATE_WRITE) begin
                status_zero_next = (status_zero_next & ~SR0_CLR_MASK) | SR0_ERR_RO;
                fail = 1'b1;
              end
            end
            ACC_NONE0, ACC_NONE4: begin
              status_zero_next = (status_zero_next & ~SR0_CLR_MASK) | SR0_ERR_NRES;
              pending = 1'b1;
            end
            default: begin
              status_zero_next = (status_zero_next & ~SR0_CLR_MASK) | SR0_ERR_NRES;
              fail = 1'b1;
            end
          endcase
          if (!fail) begin
            if (pdr[3] ? (blk < plf) : (blk > plf)) begin
              if (!pending) begin
                status_zero_next = status_zero_next & ~SR0_CLR_MASK;
              end
              status_zero_next = status_zero_next | SR0_ERR_LEN;
              fail = 1'b1;
            end else if (pending) begin
              fail = 1'b1;
            end
          end
          if (fail) begin
            status_zero_next = status_zero_next | {12'd0, addr_q[15:13], 1'b0};
            if (user_q) begin
              status_zero_next = status_zero_next | SR0_USER_MODE;
            end
            res_abort = 1'b1;
          end else begin
            res_phys = {frame, addr_q[5:0]};
          end
        end
      end else begin
        priority if (addr_q[17:1] == ADDR_SR0[17:1]) begin
          if (op_q == OP_REG_WRITE) begin
            status_zero_next = merge_word(status_zero, wd_q, addr_q[0], byte_q);
          end else begin
            res_rd = pick_word(status_zero, addr_q[0], byte_q);
          end
        end else if (addr_q[17:1] == ADDR_SR1[17:1]) begin
          if (op_q == OP_REG_WRITE) begin
            status_one_next = merge_word(status_one, wd_q, addr_q[0], byte_q);
          end else begin
            res_rd = pick_word(status_one, addr_q[0], byte_q);
          end
        end else if (addr_q[17:1] == ADDR_SR2[17:1]) begin
          if (op_q == OP_REG_READ) begin
            res_rd = pick_word(fetch_q, addr_q[0], byte_q);
          end
        end else if (addr_q[17:1] == ADDR_SR3[17:1]) begin
          if (op_q == OP_REG_WRITE) begin
            status_three_next = merge_word(status_three, wd_q, addr_q[0], byte_q);
          end else begin
            res_rd = pick_word(status_three, addr_q[0], byte_q);
          end
        end else if (q_sel.hit) begin
          if (op_q == OP_REG_WRITE) begin
            desc_we = !addr_q[5];
            par_we  = addr_q[5];
          end else begin
            res_rd = pick_word(page_old, addr_q[0], byte_q);
          end
        end else begin
          res_bad = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      done         <= 1'b0;
      status_zero  <= '0;
      status_one   <= '0;
      status_three <= '0;
      desc_vld     <= '0;
      par_vld      <= '0;
    end else begin
      status_zero  <= status_zero_next;
      status_one   <= status_one_next;
      status_three <= status_three_next;
      if (desc_we) begin
        desc_vld[idx_q] <= 1'b1;
      end
      if (par_we) begin
        par_vld[idx_q] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          done <= 1'b0;
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      phys_addr    <= res_phys;
      read_data    <= res_rd;
      abort        <= res_abort;
      bad_register <= res_bad;
    end
  end

  // A word accepted now is in execution in the cycle after, with done still low.
  a_accept_then_busy : assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !done)
    else $error("accepted word did not enter execution");

  a_busy_then_done : assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("execution did not deliver a result word");

  a_abort_no_addr : assert property (@(posedge clk) disable iff (rst)
    done && abort |-> phys_addr == '0 && !bad_register)
    else $error("aborted translation carries an address or register flag");

  a_reg_no_addr : assert property (@(posedge clk) disable iff (rst)
    done && (read_data != '0 || bad_register) |-> phys_addr == '0 && !abort)
    else $error("register access produced translation results");

endmodule
